>>> hdl/lcdbi_pkg.sv
// ----------------------------------------------------------------------------
// lcdbi_pkg
// Shared constants for the LCD controller host bus interface: video memory
// geometry and the command codes that the controller decodes.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdbi_pkg;

    // Video memory geometry; the depth is a power of two so that the cursor
    // maps to an entry by its low bits
    localparam int VRAM_WORDS = 32768;
    localparam int VRAM_AW    = $clog2(VRAM_WORDS);
    localparam int VRAM_DW    = 8;

    // Command codes
    localparam logic [7:0] CMD_SYS_SETUP   = 8'h40;
    localparam logic [7:0] CMD_MEM_WR      = 8'h42;
    localparam logic [7:0] CMD_MEM_RD      = 8'h43;
    localparam logic [7:0] CMD_CURSOR_WR   = 8'h46;
    localparam logic [7:0] CMD_CURSOR_RD   = 8'h47;
    localparam logic [7:0] CMD_DIR_RIGHT   = 8'h4c;
    localparam logic [7:0] CMD_DIR_DOWN    = 8'h4f;
    localparam logic [7:0] CMD_SLEEP       = 8'h53;
    localparam logic [7:0] CMD_DISPLAY_OFF = 8'h58;
    localparam logic [7:0] CMD_DISPLAY_ON  = 8'h59;

    // Cursor step directions
    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_UP    = 2'd2,
        DIR_DOWN  = 2'd3
    } dir_t;

    // System-set parameter positions that carry the address pitch
    localparam logic [7:0] PAR_PITCH_LO = 8'd6;
    localparam logic [7:0] PAR_PITCH_HI = 8'd7;

    // Cursor-read byte positions
    localparam logic [7:0] PAR_CSR_LO   = 8'd0;
    localparam logic [7:0] PAR_CSR_HI   = 8'd1;
    localparam logic [7:0] PAR_CSR_DONE = 8'd2;

    localparam logic [7:0] PAR_COUNT_MAX = 8'hff;

endpackage

`default_nettype wire

>>> hdl/lcd_controller_bus_interface.sv
// ----------------------------------------------------------------------------
// lcd_controller_bus_interface
// Host side of a graphic LCD controller: command decode, cursor, pitch and
// display state, backed by a synchronous video memory.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel carries one bus access (s_func: 1 write / 0 read,
//   s_port_select: 1 command / 0 parameter-data, s_write_data). Every access
//   gives exactly one transfer on the m_* channel: read byte, display active
//   flag and the cursor after the access.
//   The result is registered and valid in the cycle after the access is taken.
//   Throughput: one access per cycle unless stalled. Control state updates in
//   the accept cycle; the video memory is read and written at the accept edge,
//   so each access sees every earlier write and no forwarding is needed.
//   Reset: aresetn (synchronous, active low) clears all control state and then
//   starts a clearing pass that zeroes all VRAM_WORDS (32768) video memory
//   entries, one per cycle; s_ready stays low during the pass.
//   Stall: the result sits in the output register; a new access is taken in
//   the same cycle the pending result transfers (s_ready = !m_valid | m_ready).
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_controller_bus_interface (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_func,
    input  wire logic        s_port_select,
    input  wire logic [7:0]  s_write_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [7:0]  m_read_data,
    output logic             m_display_active,
    output logic      [15:0] m_cursor_address
);

    localparam int AW = lcdbi_pkg::VRAM_AW;

    // Control state
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  pcount_reg, pcount_next;
    logic [15:0] cursor_reg, cursor_next;
    logic [1:0]  dir_reg, dir_next;
    logic [15:0] pitch_reg, pitch_next;
    logic        disp_reg, disp_next;
    logic        sleep_reg, sleep_next;

    // Clearing pass
    logic          clr_active_reg;
    logic [AW-1:0] clr_addr_reg;

    // Output stage
    logic        m_valid_reg;
    logic        sel_mem_reg;
    logic [7:0]  rbyte_reg, rbyte_next;
    logic        active_reg;
    logic [15:0] cursor_out_reg;

    // Memory port
    logic          accept;
    logic          mem_wr, mem_rd;
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata, ram_rdata;
    logic [15:0]   cursor_step;

    assign s_ready = !clr_active_reg && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    // Cursor step for memory accesses
    always_comb begin
        case (lcdbi_pkg::dir_t'(dir_reg))
            lcdbi_pkg::DIR_LEFT:  cursor_step = cursor_reg - 16'd1;
            lcdbi_pkg::DIR_UP:    cursor_step = cursor_reg - pitch_reg;
            lcdbi_pkg::DIR_DOWN:  cursor_step = cursor_reg + pitch_reg;
            default:              cursor_step = cursor_reg + 16'd1;
        endcase
    end

    // Access decode and next state
    always_comb begin
        cmd_next    = cmd_reg;
        pcount_next = pcount_reg;
        cursor_next = cursor_reg;
        dir_next    = dir_reg;
        pitch_next  = pitch_reg;
        disp_next   = disp_reg;
        sleep_next  = sleep_reg;
        rbyte_next  = 8'd0;
        mem_wr      = 1'b0;
        mem_rd      = 1'b0;
        if (s_func && s_port_select) begin
            // command write
            cmd_next    = s_write_data;
            pcount_next = 8'd0;
            unique case (s_write_data) inside
                lcdbi_pkg::CMD_SYS_SETUP:   sleep_next = 1'b0;
                [lcdbi_pkg::CMD_DIR_RIGHT:lcdbi_pkg::CMD_DIR_DOWN]:
                    dir_next = s_write_data[1:0];
                lcdbi_pkg::CMD_SLEEP:       sleep_next = 1'b1;
                lcdbi_pkg::CMD_DISPLAY_OFF: disp_next  = 1'b0;
                lcdbi_pkg::CMD_DISPLAY_ON: begin
                    disp_next  = 1'b1;
                    sleep_next = 1'b0;
                end
                default: ;
            endcase
        end else if (s_func) begin
            // parameter write
            unique case (cmd_reg)
                lcdbi_pkg::CMD_SYS_SETUP: begin
                    if (pcount_reg == lcdbi_pkg::PAR_PITCH_LO) begin
                        pitch_next = {pitch_reg[15:8], s_write_data};
                    end else if (pcount_reg == lcdbi_pkg::PAR_PITCH_HI) begin
                        pitch_next = {s_write_data, pitch_reg[7:0]};
                    end
                end
                lcdbi_pkg::CMD_CURSOR_WR: begin
                    if (pcount_reg == lcdbi_pkg::PAR_CSR_LO) begin
                        cursor_next = {cursor_reg[15:8], s_write_data};
                    end else if (pcount_reg == lcdbi_pkg::PAR_CSR_HI) begin
                        cursor_next = {s_write_data, cursor_reg[7:0]};
                    end
                end
                lcdbi_pkg::CMD_MEM_WR: begin
                    mem_wr      = 1'b1;
                    cursor_next = cursor_step;
                end
                default: ;
            endcase
            if (pcount_reg != lcdbi_pkg::PAR_COUNT_MAX) begin
                pcount_next = pcount_reg + 8'd1;
            end
        end else if (!s_port_select) begin
            // data read
            unique case (cmd_reg)
                lcdbi_pkg::CMD_MEM_RD: begin
                    mem_rd      = 1'b1;
                    cursor_next = cursor_step;
                end
                lcdbi_pkg::CMD_CURSOR_RD: begin
                    if (pcount_reg == lcdbi_pkg::PAR_CSR_LO) begin
                        rbyte_next = cursor_reg[7:0];
                    end else if (pcount_reg == lcdbi_pkg::PAR_CSR_HI) begin
                        rbyte_next = cursor_reg[15:8];
                    end
                    if (pcount_reg < lcdbi_pkg::PAR_CSR_DONE) begin
                        pcount_next = pcount_reg + 8'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Video memory port: clearing pass owns it after reset
    assign ram_we    = clr_active_reg || (accept && mem_wr);
    assign ram_re    = accept && mem_rd;
    assign ram_addr  = clr_active_reg ? clr_addr_reg : cursor_reg[AW-1:0];
    assign ram_wdata = clr_active_reg ? 8'd0 : s_write_data;

    lcdbi_ram #(
        .AW (AW),
        .DW (lcdbi_pkg::VRAM_DW)
    ) u_vram (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Control state, clearing pass and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg        <= 8'd0;
            pcount_reg     <= 8'd0;
            cursor_reg     <= 16'd0;
            dir_reg        <= lcdbi_pkg::DIR_RIGHT;
            pitch_reg      <= 16'd0;
            disp_reg       <= 1'b0;
            sleep_reg      <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            m_valid_reg    <= 1'b0;
            sel_mem_reg    <= 1'b0;
        end else begin
            if (clr_active_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(lcdbi_pkg::VRAM_WORDS - 1)) begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (accept) begin
                cmd_reg     <= cmd_next;
                pcount_reg  <= pcount_next;
                cursor_reg  <= cursor_next;
                dir_reg     <= dir_next;
                pitch_reg   <= pitch_next;
                disp_reg    <= disp_next;
                sleep_reg   <= sleep_next;
                m_valid_reg <= 1'b1;
                sel_mem_reg <= mem_rd;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            rbyte_reg      <= rbyte_next;
            active_reg     <= disp_next && !sleep_next;
            cursor_out_reg <= cursor_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_read_data      = sel_mem_reg ? ram_rdata : rbyte_reg;
    assign m_display_active = active_reg;
    assign m_cursor_address = cursor_out_reg;

`ifndef SYNTHESIS
    // No access is taken while the memory is being cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !s_ready)
        else $error("access accepted during video memory clear");

    // The clearing pass ends after visiting the last entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(clr_active_reg) |-> (clr_addr_reg == '0))
        else $error("clearing pass ended early");

    // Outside the clear, memory writes come only from memory-write parameters
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && !clr_active_reg) |->
            (cmd_reg == lcdbi_pkg::CMD_MEM_WR && s_func && !s_port_select))
        else $error("unexpected video memory write");

    // A memory read returns its byte from the RAM in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && mem_rd) |=> (m_valid && sel_mem_reg))
        else $error("memory read result not routed from RAM");
`endif

endmodule

`default_nettype wire

>>> hdl/lcdbi_ram.sv
// ----------------------------------------------------------------------------
// lcdbi_ram
// Single-port synchronous RAM, one access per cycle, registered read data
// that holds until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdbi_ram #(
    parameter int AW = 15,
    parameter int DW = 8
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic          re,
    input  wire logic [AW-1:0] addr,
    input  wire logic [DW-1:0] wdata,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [0:(1<<AW)-1];
    logic [DW-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
